// ===== sv/sck_pkg.sv =====
// Package for the slider-crank kinematics block: constants and the CORDIC angle table.
package sck_pkg;

  localparam int unsigned MinRadius   = 66;
  localparam int unsigned CordicIters = 30;
  localparam int unsigned RegW        = 18;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // register indexes on the configuration port
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_ROD    = 2'd1;
  localparam logic [1:0] REG_DT     = 2'd2;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/slider_crank_kinematics.sv =====
// Slider-crank kinematics: iterative CORDIC, multiply, root and divide under one sequencer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | crank_angle, length_error
//  out     | output    | out_valid/out_stall| slider_position, velocity, acceleration
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item runs 30 CORDIC steps, 4 multiplies and 19 root steps, then two divisions by dt
// (a division is skipped when its quotient saturates); both divisions are skipped when
// dt is zero. The next item is accepted only after the current one is finished.
// The sequencer holds one item at a time; in_stall is high while it works.
// Reset (synchronous, rst_n low) restores the register defaults and clears history.
// A finished item waits in the output register while out_stall is high; the next one
// then waits in the sequencer, which holds in_stall high.
module slider_crank_kinematics
  import sck_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_crank_angle,
  input  logic signed [16:0]  in_length_error,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_slider_position,
  output logic signed [31:0]  out_slider_velocity,
  output logic signed [31:0]  out_slider_acceleration,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CORD = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_POS  = 4'd4;
  localparam logic [3:0] S_DSET = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  localparam logic signed [31:0] SatMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  logic [3:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [RegW-1:0] radius_r, rod_r, dt_r;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic signed [19:0] le_r, le_nxt;
  logic signed [20:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [54:0] sq_r, sq_nxt;
  logic [37:0]        rem_r, rem_nxt, res_r, res_nxt;
  logic signed [31:0] pos_r, pos_nxt, vel_r, vel_nxt, acc_r, acc_nxt;
  logic signed [31:0] prev_pos_r, prev_pos_nxt, prev_vel_r, prev_vel_nxt;
  logic               which_r, which_nxt, neg_r, neg_nxt;
  logic [18:0]        drem_r, drem_nxt;
  logic [30:0]        q_r, q_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] opos_r, opos_nxt, ovel_r, ovel_nxt, oacc_r, oacc_nxt;

  logic [RegW-1:0]    r_eff, len_eff;
  logic signed [33:0] z_in, sx, sy, at;
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] prod, rnd, argw;
  logic [37:0]        bitv, trial;
  logic [20:0]        root;
  logic signed [33:0] pos_w;
  logic signed [32:0] diff;
  logic signed [49:0] num, mag;
  logic [19:0]        dtry;
  logic signed [31:0] qs;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_slider_position     = opos_r;
  assign out_slider_velocity     = ovel_r;
  assign out_slider_acceleration = oacc_r;

  // effective radius and rod length
  always_comb begin
    r_eff   = (radius_r < RegW'(MinRadius)) ? RegW'(MinRadius) : radius_r;
    len_eff = (rod_r < r_eff) ? r_eff : rod_r;
  end

  // datapath
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; flip_nxt = flip_r; le_nxt = le_r;
    px_nxt = px_r; py_nxt = py_r; sq_nxt = sq_r; rem_nxt = rem_r; res_nxt = res_r;
    pos_nxt = pos_r; vel_nxt = vel_r; acc_nxt = acc_r;
    prev_pos_nxt = prev_pos_r; prev_vel_nxt = prev_vel_r;
    which_nxt = which_r; neg_nxt = neg_r; drem_nxt = drem_r; q_nxt = q_r;
    out_valid_nxt = out_valid_r && out_stall;
    opos_nxt = opos_r; ovel_nxt = ovel_r; oacc_nxt = oacc_r;

    // angle folded into +-90 degrees
    z_in = 34'(signed'({in_crank_angle, 16'h0}));
    sx = x_r >>> cnt_r;
    sy = y_r >>> cnt_r;
    at = atan_turn(cnt_r);

    // shared multiplier operand select
    case (cnt_r[1:0])
      2'd0: begin mul_a = flip_r ? -y_r : y_r; mul_b = 21'(r_eff); end
      2'd1: begin mul_a = flip_r ? -x_r : x_r; mul_b = 21'(r_eff); end
      2'd2: begin mul_a = 34'(le_r);           mul_b = 21'(le_r);  end
      default: begin mul_a = 34'(py_r);        mul_b = py_r;       end
    endcase
    prod = 55'(mul_a) * 55'(mul_b);
    rnd  = (prod + (55'sd1 <<< 29)) >>> 30;
    argw = sq_r - prod;

    bitv  = 38'd1 << {cnt_r, 1'b0};
    trial = res_r + bitv;
    root  = 21'(res_r) + 21'(rem_r > res_r);
    pos_w = 34'(px_r) + 34'(signed'({1'b0, root})) - 34'(le_r);

    diff = which_r ? (33'(vel_r) - 33'(prev_vel_r)) : (33'(pos_r) - 33'(prev_pos_r));
    num  = 50'(diff) <<< 16;
    mag  = (num < 0) ? -num : num;
    dtry = {drem_r, q_r[30]};
    qs   = neg_r ? -32'(signed'({1'b0, q_r})) : 32'(signed'({1'b0, q_r}));

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (z_in > 34'sd1073741824) begin
            z_nxt = z_in - 34'sd2147483648; flip_nxt = 1'b1;
          end else if (z_in < -34'sd1073741824) begin
            z_nxt = z_in + 34'sd2147483648; flip_nxt = 1'b1;
          end else begin
            z_nxt = z_in; flip_nxt = 1'b0;
          end
          x_nxt = CordicGain; y_nxt = '0;
          le_nxt = 20'(signed'({2'b0, len_eff})) + 20'(in_length_error);
          cnt_nxt = '0;
          state_nxt = S_CORD;
        end
      end
      // one rotation step a cycle
      S_CORD: begin
        if (z_r >= 0) begin
          x_nxt = x_r - sy; y_nxt = y_r + sx; z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + sy; y_nxt = y_r - sx; z_nxt = z_r + at;
        end
        if (cnt_r == 5'(CordicIters - 1)) begin
          cnt_nxt = '0; state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      // px, py, le^2, then root argument
      S_MUL: begin
        case (cnt_r[1:0])
          2'd0: px_nxt = rnd[20:0];
          2'd1: py_nxt = rnd[20:0];
          2'd2: sq_nxt = prod;
          default: begin
            rem_nxt = (argw < 0) ? '0 : argw[37:0];
            res_nxt = '0;
          end
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = 5'd18; state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      // one result bit a cycle
      S_SQRT: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial; res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        if (cnt_r == 5'd0) state_nxt = S_POS;
        else cnt_nxt = cnt_r - 5'd1;
      end
      S_POS: begin
        if (pos_w > 34'(SatMax)) pos_nxt = SatMax;
        else if (pos_w < 34'(SatMin)) pos_nxt = SatMin;
        else pos_nxt = pos_w[31:0];
        which_nxt = 1'b0;
        if (dt_r == '0) begin
          vel_nxt = '0; acc_nxt = '0; state_nxt = S_FIN;
        end else begin
          state_nxt = S_DSET;
        end
      end
      // overflow check, then preload the high dividend bits
      S_DSET: begin
        neg_nxt = (num < 0);
        if (mag >= 50'(signed'({1'b0, dt_r, 31'h0}))) begin
          if (which_r) acc_nxt = (num < 0) ? SatMin : SatMax;
          else         vel_nxt = (num < 0) ? SatMin : SatMax;
          which_nxt = 1'b1;
          state_nxt = which_r ? S_FIN : S_DSET;
        end else begin
          drem_nxt = mag[49:31];
          q_nxt = mag[30:0];
          cnt_nxt = 5'd30;
          state_nxt = S_DIV;
        end
      end
      // restoring division, one quotient bit a cycle
      S_DIV: begin
        if (dtry >= 20'(dt_r)) begin
          drem_nxt = 19'(dtry - 20'(dt_r)); q_nxt = {q_r[29:0], 1'b1};
        end else begin
          drem_nxt = dtry[18:0]; q_nxt = {q_r[29:0], 1'b0};
        end
        if (cnt_r == 5'd0) begin
          state_nxt = S_FIN;
          if (!which_r) begin
            which_nxt = 1'b1; state_nxt = S_DSET;
          end
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_FIN: begin
        // copy the results to the output and the history once the output register is free
        if (!(out_valid_r && out_stall)) begin
          opos_nxt = pos_r; ovel_nxt = vel_r; oacc_nxt = acc_r;
          prev_pos_nxt = pos_r; prev_vel_nxt = vel_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // latch quotient when a division finishes
    if (state_r == S_DIV && cnt_r == 5'd0) begin
      if (dtry >= 20'(dt_r)) begin
        qs = neg_r ? -32'(signed'({1'b0, q_r[29:0], 1'b1}))
                   :  32'(signed'({1'b0, q_r[29:0], 1'b1}));
      end else begin
        qs = neg_r ? -32'(signed'({1'b0, q_r[29:0], 1'b0}))
                   :  32'(signed'({1'b0, q_r[29:0], 1'b0}));
      end
      if (which_r) acc_nxt = qs;
      else         vel_nxt = qs;
    end
  end

  // state, configuration and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      radius_r <= RegW'(13107);
      rod_r <= RegW'(32768);
      dt_r <= RegW'(6554);
      prev_pos_r <= '0;
      prev_vel_r <= '0;
      which_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      prev_pos_r <= prev_pos_nxt;
      prev_vel_r <= prev_vel_nxt;
      which_r <= which_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS: radius_r <= cfg_data[RegW-1:0];
          REG_ROD:    rod_r    <= cfg_data[RegW-1:0];
          REG_DT:     dt_r     <= cfg_data[RegW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; flip_r <= flip_nxt; le_r <= le_nxt;
    px_r <= px_nxt; py_r <= py_nxt; sq_r <= sq_nxt; rem_r <= rem_nxt; res_r <= res_nxt;
    pos_r <= pos_nxt; vel_r <= vel_nxt; acc_r <= acc_nxt;
    neg_r <= neg_nxt; drem_r <= drem_nxt; q_r <= q_nxt;
    opos_r <= opos_nxt; ovel_r <= ovel_nxt; oacc_r <= oacc_nxt;
  end

`ifndef ASSERT_OFF
  // an accepted item makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");
  // rotation counter stays in range
  a_cord: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORD) |-> (cnt_r < 5'(CordicIters))) else $error("cordic count");
  // a new result always carries the history it stores
  a_hist: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (prev_pos_r == opos_r && prev_vel_r == ovel_r))
    else $error("history mismatch");
`endif

endmodule

// ===== verif/slider_crank_kinematics_chk.sv =====
// Checker for the slider-crank block: predicts each result and compares it with the DUT output.
`timescale 1ns / 100ps

module slider_crank_kinematics_chk
  import sck_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        in_crank_angle,
  input  logic signed [16:0] in_length_error,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_slider_position,
  input  logic signed [31:0] out_slider_velocity,
  input  logic signed [31:0] out_slider_acceleration,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } motion_t;

  typedef longint unsigned u64_t;

  // atan(2^-i) in 2^-32 turn
  localparam longint AtanTab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  motion_t expected_motion[$];
  logic [17:0] radius_q, rod_q, dt_q;
  longint last_pos, last_vel;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rotation-mode CORDIC with quadrant folding, Q2.30 results
  function automatic void crank_sincos(input logic [15:0] ang, output longint s,
                                       output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) <<< 16;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= AtanTab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += AtanTab[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // bitwise integer root, rounded to nearest
  function automatic longint root_nearest(input u64_t a);
    u64_t res, bt, rem;
    res = 0;
    bt  = 64'd1 << 62;
    rem = a;
    while (bt > rem) bt >>= 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    if (rem > res) res++;
    return longint'(res);
  endfunction

  function automatic motion_t slider_motion(input logic [15:0] ang,
                                            input logic signed [16:0] err);
    longint r, len, le, s30, c30, px, py, arg, pos, vel, acc, dt;
    motion_t m;
    r   = (radius_q < MinRadius) ? longint'(MinRadius) : longint'(radius_q);
    len = (longint'(rod_q) < r) ? r : longint'(rod_q);
    le  = len + longint'(err);
    dt  = longint'(dt_q);
    crank_sincos(ang, s30, c30);
    px  = (r * s30 + (64'sd1 <<< 29)) >>> 30;
    py  = (r * c30 + (64'sd1 <<< 29)) >>> 30;
    arg = le * le - py * py;
    if (arg < 0) arg = 0;
    pos = clip32(px + root_nearest(u64_t'(arg)) - le);
    vel = 0;
    acc = 0;
    if (dt > 0) begin
      vel = clip32(((pos - last_pos) * 65536) / dt);
      acc = clip32(((vel - last_vel) * 65536) / dt);
    end
    last_pos = pos;
    last_vel = vel;
    m.pos = pos[31:0];
    m.vel = vel[31:0];
    m.acc = acc[31:0];
    return m;
  endfunction

  always @(posedge clk) begin
    motion_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      radius_q <= 18'd13107;
      rod_q    <= 18'd32768;
      dt_q     <= 18'd6554;
      last_pos = 0;
      last_vel = 0;
      expected_motion.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS: radius_q <= cfg_data[17:0];
          REG_ROD:    rod_q    <= cfg_data[17:0];
          REG_DT:     dt_q     <= cfg_data[17:0];
          default: ;
        endcase
      end
      // accepted item
      if (in_valid && !in_stall)
        expected_motion.insert(expected_motion.size(),
                               slider_motion(in_crank_angle, in_length_error));
      // accepted result
      if (out_valid && !out_stall) begin
        if (expected_motion.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          want = expected_motion.pop_front();
          if (want.pos !== out_slider_position) begin
            $error("slider_position expected %0d got %0d", want.pos, out_slider_position);
            errs++;
          end
          if (want.vel !== out_slider_velocity) begin
            $error("slider_velocity expected %0d got %0d", want.vel, out_slider_velocity);
            errs++;
          end
          if (want.acc !== out_slider_acceleration) begin
            $error("slider_acceleration expected %0d got %0d", want.acc,
                   out_slider_acceleration);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= expected_motion.size();
    end
  end

endmodule

// ===== verif/slider_crank_kinematics_tb.sv =====
// Testbench top for the slider-crank block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module slider_crank_kinematics_tb
  import sck_pkg::*;
();

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [15:0]        in_crank_angle = '0;
  logic signed [16:0] in_length_error = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_slider_position, out_slider_velocity, out_slider_acceleration;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 fail_count, pending_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_tgl = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  slider_crank_kinematics u_dut (.*);
  slider_crank_kinematics_chk u_chk (.*);

  // receiver: random stalls, or a long counted hold-off when requested
  always @(posedge clk) begin
    static bit seen_tgl = 0;
    static int hold_left = 0;
    if (hold_tgl != seen_tgl) begin
      seen_tgl = hold_tgl;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // offer one item, idling first at random; valid stays high into the next item
  task automatic send_item(input logic [15:0] ang, input logic signed [16:0] err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_crank_angle  <= ang;
    in_length_error <= err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // one register write, then the port goes quiet
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [31:0] r, input logic [31:0] l,
                              input logic [31:0] dt);
    write_reg(REG_RADIUS, r);
    write_reg(REG_ROD, l);
    write_reg(REG_DT, dt);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(5))
      0: return $urandom_range(70);
      1: return 32'h3FFFF;
      2: return {$urandom} | 32'hFFFC_0000;
      default: return $urandom_range(20000, 80000);
    endcase
  endfunction

  function automatic logic signed [16:0] pick_err();
    case ($urandom_range(3))
      0: return 17'($urandom);
      1: return $signed(17'($urandom_range(65536)) - 17'sd32768) >>> 4;
      default: return $signed(17'($urandom_range(2000))) - 17'sd1000;
    endcase
  endfunction

  initial begin
    logic [15:0] sweep_ang;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: quadrant edges and fold points at reset geometry
    send_item(16'd0, 17'sd0);
    send_item(16'd16384, 17'sd0);
    send_item(16'd16385, 17'sd0);
    send_item(16'd32768, 17'sd0);
    send_item(16'd49152, 17'sd0);
    send_item(16'd49151, 17'sd0);
    send_item(16'd65535, 17'sd65535);
    send_item(16'd1, -17'sd65536);
    drain();

    // tiny radius, shortest rod, zero time step, ignored index
    set_geometry(32'd0, 32'd66, 32'd0);
    write_reg(2'd3, 32'hFFFF_FFFF);
    send_item(16'd8192, 17'sd0);
    send_item(16'd40000, -17'sd65536);
    send_item(16'd20000, 17'sd65535);
    drain();

    // widest crank, rod shorter than crank, dt of one LSB to force saturation
    set_geometry(32'h3FFFF, 32'd66, 32'd1);
    send_item(16'd16384, -17'sd65536);
    send_item(16'd0, 17'sd65535);
    send_item(16'd32768, -17'sd65536);
    send_item(16'd12000, 17'sd0);
    drain();

    // longest rod and time step, negative effective length
    set_geometry(32'd70, 32'h3FFFF, 32'h3FFFF);
    send_item(16'd0, -17'sd65536);
    send_item(16'd49152, 17'sd65535);
    drain();
    set_geometry(32'd66, 32'd66, 32'd6554);
    send_item(16'd30000, -17'sd65536);
    send_item(16'd5000, -17'sd100);
    drain();

    // random phases: idling patterns crossed with geometries
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0) set_geometry(32'd13107, 32'd32768, 32'd6554);
      else set_geometry(pick_reg(), pick_reg(), (ph == 5) ? 32'd0 : pick_reg());
      if (ph == 0) hold_tgl = ~hold_tgl;
      sweep_ang = 16'($urandom);
      for (int n = 0; n < 80; n++) begin
        // mostly a steadily turning crank, some arbitrary jumps
        if ($urandom_range(9) < 7) sweep_ang += 16'($urandom_range(1500));
        else sweep_ang = 16'($urandom);
        send_item(sweep_ang, pick_err());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("slider_crank_kinematics test passed");
    end else begin
      $display("slider_crank_kinematics test failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("slider_crank_kinematics test failed");
    $finish;
  end

endmodule
